[sv/grid_max_path_sum_defines.svh]
// ---------------------------------------------------------------------------
// grid_max_path_sum_defines
// Assertion macros used by the grid_max_path_sum RTL.
// ---------------------------------------------------------------------------
`ifndef GRID_MAX_PATH_SUM_DEFINES_SVH
`define GRID_MAX_PATH_SUM_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define GMPS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grid_max_path_sum: assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define GMPS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grid_max_path_sum: assertion failed");

`endif

[sv/gmps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gmps_pkg
// Types and constants of the grid maximum path sum block.
// ---------------------------------------------------------------------------
package gmps_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int SIZE_W   = 7;
	localparam int CELL_W   = 16;
	localparam int SUM_W    = 22;
	localparam int ADDR_W   = ROW_W + 1;
	localparam int IDX_W    = 2;

	typedef logic [CELL_W-1:0] cell_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [SIZE_W-1:0] size_t;

	localparam sum_t SUM_MAX = {SUM_W{1'b1}};

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_ROWS = 2'd0;
	localparam logic [IDX_W-1:0] REG_COLS = 2'd1;

	// Which predecessors of a cell take part in its sum.
	typedef struct packed {
		logic first_col;
		logic has_up;
		logic has_down;
	} pred_ctl_t;

endpackage
`default_nettype wire

[sv/gmps_sum_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gmps_sum_unit
// Best predecessor sum plus cell, saturating; first column: the cell alone.
// ---------------------------------------------------------------------------
module gmps_sum_unit (
	input  var gmps_pkg::pred_ctl_t ctl,
	input  var gmps_pkg::cell_t     cell_val,
	input  var gmps_pkg::sum_t      p_up,
	input  var gmps_pkg::sum_t      p_mid,
	input  var gmps_pkg::sum_t      p_down,
	output gmps_pkg::sum_t          sum
);

	gmps_pkg::sum_t              best;
	logic [gmps_pkg::SUM_W:0]    wide;

	always_comb begin
		best = p_mid;
		if (ctl.has_up && (p_up > best)) begin
			best = p_up;
		end
		if (ctl.has_down && (p_down > best)) begin
			best = p_down;
		end
		wide = {1'b0, best} + {{(gmps_pkg::SUM_W + 1 - gmps_pkg::CELL_W){1'b0}}, cell_val};
		if (ctl.first_col) begin
			sum = {{(gmps_pkg::SUM_W - gmps_pkg::CELL_W){1'b0}}, cell_val};
		end else if (wide[gmps_pkg::SUM_W]) begin
			sum = gmps_pkg::SUM_MAX;
		end else begin
			sum = wide[gmps_pkg::SUM_W-1:0];
		end
	end

endmodule
`default_nettype wire

[sv/grid_max_path_sum.sv]
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one cell per cycle unless the input stalls; the single sum stage and the column
// memory (one write port, two read ports) each take one access per cell.
// Result: the last cell of a grid passes the sum stage register, then best_total is registered.
// Input stalls only while a finished total waits and the next grid's last cell is ready.
// Reset: grid size 4 x 4, counters and running best cleared; memory is not cleared.
// ---------------------------------------------------------------------------
// grid_max_path_sum
// Column-major streaming dynamic program for the maximum grid path sum.
// ---------------------------------------------------------------------------
`include "grid_max_path_sum_defines.svh"

module grid_max_path_sum (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [15:0] s_axis_tdata,   // [15:0] cell_value
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [21:0] best_total, [23:22] zero
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [6:0]  cfg_data
);

	localparam int ROW_W  = gmps_pkg::ROW_W;
	localparam int COL_W  = gmps_pkg::COL_W;
	localparam int SIZE_W = gmps_pkg::SIZE_W;
	localparam int ADDR_W = gmps_pkg::ADDR_W;

	// Two banks of per-row sums: {bank, row}.
	gmps_pkg::sum_t mem [0:(2*gmps_pkg::MAX_ROWS)-1];

	gmps_pkg::size_t  n_rows_q, n_cols_q, cfg_clamped, cfg_limit;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             bank_q;
	gmps_pkg::sum_t   best_q;

	logic in_fire, fire_s1, last_row_in, last_col_in, row0_in;
	logic [ADDR_W-1:0] addr_a, addr_b, wr_addr;

	logic                v_s1;
	gmps_pkg::cell_t     cell_s1;
	logic [ROW_W-1:0]    row_s1;
	logic                bank_s1, row0_s1, last_col_s1, final_s1;
	gmps_pkg::pred_ctl_t ctl_s1;
	gmps_pkg::sum_t      rd_a_s1, rd_b_s1, fwd_data_s1;
	logic                fwd_a_s1, fwd_b_s1;

	gmps_pkg::sum_t eff_a, eff_b, p_up, p_mid, p_down, sum_s1, new_best;
	gmps_pkg::sum_t win_up_q, win_mid_q;

	logic              out_valid_q;
	gmps_pkg::sum_t    out_data_q;

	// Size registers are stored already clamped to 1..MAX.
	always_comb begin
		cfg_limit = (cfg_index == gmps_pkg::REG_COLS) ? SIZE_W'(gmps_pkg::MAX_COLS)
			: SIZE_W'(gmps_pkg::MAX_ROWS);
		if (cfg_data == '0) begin
			cfg_clamped = SIZE_W'(1);
		end else if (cfg_data > cfg_limit) begin
			cfg_clamped = cfg_limit;
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	assign fire_s1       = v_s1 && !(final_s1 && out_valid_q && !m_axis_tready);
	assign s_axis_tready = !v_s1 || fire_s1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	assign last_row_in = ({1'b0, row_q} == (n_rows_q - SIZE_W'(1)));
	assign last_col_in = ({1'b0, col_q} == (n_cols_q - SIZE_W'(1)));
	assign row0_in     = (row_q == '0);

	// Row 0 reads rows 0 and 1 of the previous column; later rows read one row ahead.
	assign addr_a  = {~bank_q, row0_in ? {ROW_W{1'b0}} : (row_q + ROW_W'(1))};
	assign addr_b  = {~bank_q, ROW_W'(1)};
	assign wr_addr = {bank_s1, row_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_rows_q <= SIZE_W'(4);
			n_cols_q <= SIZE_W'(4);
		end else if (cfg_we) begin
			case (cfg_index)
				gmps_pkg::REG_ROWS: n_rows_q <= cfg_clamped;
				gmps_pkg::REG_COLS: n_cols_q <= cfg_clamped;
				default: ;
			endcase
		end
	end

	// Position of the next cell to be accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			bank_q <= 1'b0;
		end else if (cfg_we && (cfg_index inside {gmps_pkg::REG_ROWS, gmps_pkg::REG_COLS})) begin
			row_q  <= '0;
			col_q  <= '0;
			bank_q <= 1'b0;
		end else if (in_fire) begin
			if (last_row_in) begin
				row_q <= '0;
				if (last_col_in) begin
					col_q  <= '0;
					bank_q <= 1'b0;
				end else begin
					col_q  <= col_q + COL_W'(1);
					bank_q <= ~bank_q;
				end
			end else begin
				row_q <= row_q + ROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= 1'b1;
		end else if (fire_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cell_s1            <= s_axis_tdata;
			row_s1             <= row_q;
			bank_s1            <= bank_q;
			row0_s1            <= row0_in;
			last_col_s1        <= last_col_in;
			final_s1           <= last_col_in && last_row_in;
			ctl_s1.first_col   <= (col_q == '0);
			ctl_s1.has_up      <= !row0_in;
			ctl_s1.has_down    <= !last_row_in;
		end
	end

	// Column memory; a write in the same edge as a read is forwarded.
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			mem[wr_addr] <= sum_s1;
		end
		if (in_fire) begin
			rd_a_s1     <= mem[addr_a];
			rd_b_s1     <= mem[addr_b];
			fwd_a_s1    <= fire_s1 && (wr_addr == addr_a);
			fwd_b_s1    <= fire_s1 && (wr_addr == addr_b);
			fwd_data_s1 <= sum_s1;
		end
	end

	assign eff_a  = fwd_a_s1 ? fwd_data_s1 : rd_a_s1;
	assign eff_b  = fwd_b_s1 ? fwd_data_s1 : rd_b_s1;
	assign p_up   = win_up_q;
	assign p_mid  = row0_s1 ? eff_a : win_mid_q;
	assign p_down = row0_s1 ? eff_b : eff_a;

	gmps_sum_unit u_sum (
		.ctl      (ctl_s1),
		.cell_val (cell_s1),
		.p_up     (p_up),
		.p_mid    (p_mid),
		.p_down   (p_down),
		.sum      (sum_s1)
	);

	// The previous column slides down by one row per cell.
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			win_up_q  <= p_mid;
			win_mid_q <= p_down;
		end
	end

	assign new_best = (row0_s1 || (sum_s1 > best_q)) ? sum_s1 : best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (cfg_we && (cfg_index inside {gmps_pkg::REG_ROWS, gmps_pkg::REG_COLS})) begin
			best_q <= '0;
		end else if (fire_s1 && last_col_s1) begin
			best_q <= final_s1 ? '0 : new_best;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && final_s1) begin
			out_data_q <= new_best;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_data_q};

	`GMPS_ASSERT_IMP(a_stall_only_on_result, !s_axis_tready,
		v_s1 && final_s1 && out_valid_q && !m_axis_tready)
	`GMPS_ASSERT_IMP(a_row_in_range, 1'b1, {1'b0, row_q} < n_rows_q)
	`GMPS_ASSERT_IMP(a_no_result_overrun, fire_s1 && final_s1,
		!out_valid_q || m_axis_tready)
	`GMPS_ASSERT_NXT(a_final_gives_result, fire_s1 && final_s1, m_axis_tvalid)

endmodule
`default_nettype wire

[bench/grid_max_path_sum_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_max_path_sum_checker
// Watches the cell, total and register ports of the grid path sum block,
// keeps its own column-by-column model of the best path sums and checks
// every total that leaves the block against the oldest predicted one.
// ---------------------------------------------------------------------------
module grid_max_path_sum_checker import gmps_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	input  wire        s_axis_tready,
	input  wire [15:0] s_axis_tdata,   // [15:0] cell_value
	input  wire        m_axis_tvalid,
	input  wire        m_axis_tready,
	input  wire [23:0] m_axis_tdata,   // [21:0] best_total, [23:22] zero
	input  wire        cfg_we,
	input  wire [1:0]  cfg_index,
	input  wire [6:0]  cfg_data,
	output int         mismatches,
	output int         outstanding,
	output int         cells_seen,
	output int         totals_seen
);

	// Two banks of per-row path sums: one for the column being filled, one for
	// the column before it.
	sum_t        path_sum [2][MAX_ROWS];
	logic        fill_bank;
	int unsigned row_pos;
	int unsigned col_pos;
	sum_t        last_col_best;
	size_t       rows_reg;
	size_t       cols_reg;
	sum_t        totals_due [$];

	int fail_cnt  = 0;
	int cell_cnt  = 0;
	int total_cnt = 0;
	int due_cnt   = 0;

	assign mismatches  = fail_cnt;
	assign outstanding = due_cnt;
	assign cells_seen  = cell_cnt;
	assign totals_seen = total_cnt;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fail_cnt++;
	endtask

	function automatic int unsigned clamp_size(input size_t v, input int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic restart_grid();
		fill_bank     = 1'b0;
		row_pos       = 0;
		col_pos       = 0;
		last_col_best = '0;
	endtask

	task automatic take_cell(input cell_t v);
		int unsigned    nrows;
		int unsigned    ncols;
		logic           prev_bank;
		sum_t           pick;
		logic [SUM_W:0] wide;
		sum_t           s;
		nrows     = clamp_size(rows_reg, MAX_ROWS);
		ncols     = clamp_size(cols_reg, MAX_COLS);
		prev_bank = ~fill_bank;
		if (col_pos == 0) begin
			s = sum_t'(v);
		end else begin
			pick = path_sum[prev_bank][row_pos];
			if (row_pos > 0 && path_sum[prev_bank][row_pos-1] > pick)
				pick = path_sum[prev_bank][row_pos-1];
			if (row_pos + 1 < nrows && path_sum[prev_bank][row_pos+1] > pick)
				pick = path_sum[prev_bank][row_pos+1];
			wide = {1'b0, pick} + v;
			s    = (wide > SUM_MAX) ? SUM_MAX : wide[SUM_W-1:0];
		end
		path_sum[fill_bank][row_pos] = s;

		// The first row of the last column always replaces what an earlier grid left.
		if (col_pos + 1 >= ncols && (row_pos == 0 || s > last_col_best))
			last_col_best = s;

		row_pos++;
		if (row_pos >= nrows) begin
			row_pos   = 0;
			fill_bank = ~fill_bank;
			col_pos++;
			if (col_pos >= ncols) begin
				totals_due = {totals_due, last_col_best};
				restart_grid();
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg = size_t'(4);
			cols_reg = size_t'(4);
			restart_grid();
			totals_due.delete();
			due_cnt = 0;
		end else begin
			// A total can never leave in the same cycle as the cell that finished it,
			// so outputs are matched before this cycle's cell is modeled.
			if (m_axis_tvalid && m_axis_tready) begin
				total_cnt++;
				if (totals_due.size() == 0) begin
					report_mismatch($sformatf("best_total %0d arrived with no grid finished",
						m_axis_tdata[SUM_W-1:0]));
				end else begin
					sum_t want;
					want = totals_due.pop_front();
					if (m_axis_tdata !== {2'b00, want})
						report_mismatch($sformatf("best_total got %0d (tdata %h), expected %0d",
							m_axis_tdata[SUM_W-1:0], m_axis_tdata, want));
				end
			end

			// Any write to a real register drops the grid in progress.
			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS: begin
						rows_reg = cfg_data;
						restart_grid();
					end
					REG_COLS: begin
						cols_reg = cfg_data;
						restart_grid();
					end
					default: ;
				endcase
			end

			if (s_axis_tvalid && s_axis_tready) begin
				cell_cnt++;
				take_cell(s_axis_tdata);
			end
			due_cnt = totals_due.size();
		end
	end

endmodule

[bench/grid_max_path_sum_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_max_path_sum_tb
// Streams grids of many sizes into the block, from one cell to 64 rows or
// 64 columns, with random gaps on the cell side and random stalls on the
// total side, and lets the checker compare every best path total.
// ---------------------------------------------------------------------------
module grid_max_path_sum_tb;
	import gmps_pkg::*;

	// Indexes past the register list; writes there must change nothing.
	localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam int CELL_TARGET = 2000;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;   // [15:0] cell_value
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;         // [21:0] best_total, [23:22] zero
	logic        cfg_we        = 1'b0;
	logic [1:0]  cfg_index     = '0;
	logic [6:0]  cfg_data      = '0;

	int mismatches;
	int outstanding;
	int cells_seen;
	int totals_seen;

	int          tx_idle_pct   = 18;
	int          rx_idle_pct   = 73;
	int          hold_off_left = 0;
	int unsigned grid_cells    = 16;
	int          settings_used = 0;
	int          grids_cut     = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	grid_max_path_sum dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	grid_max_path_sum_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.cells_seen    (cells_seen),
		.totals_seen   (totals_seen)
	);

	// Total side: random stalls, or a counted hold-off when one is requested.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_off_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		#(5_000_000);
		$display("grid_max_path_sum test failed");
		$finish;
	end

	// Entered and left at a falling edge; valid stays high between back-to-back items.
	task automatic push_cell(input cell_t v);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Writes only once every finished grid has delivered its total.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input size_t val);
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_size(input size_t rows_v, input size_t cols_v);
		int unsigned nr;
		int unsigned nc;
		write_reg(REG_ROWS, rows_v);
		write_reg(REG_COLS, cols_v);
		nr = (rows_v == 0) ? 1 : ((rows_v > MAX_ROWS) ? MAX_ROWS : rows_v);
		nc = (cols_v == 0) ? 1 : ((cols_v > MAX_COLS) ? MAX_COLS : cols_v);
		grid_cells = nr * nc;
		settings_used++;
	endtask

	task automatic push_grid(input int unsigned n, input bit all_max);
		cell_t v;
		for (int unsigned i = 0; i < n; i++) begin
			if (all_max) begin
				v = '1;
			end else begin
				case ($urandom_range(9))
					0:       v = '0;
					1:       v = '1;
					default: v = cell_t'($urandom);
				endcase
			end
			push_cell(v);
		end
	endtask

	initial begin
		cell_t       grid4 [16];
		size_t       rows_v;
		size_t       cols_v;
		bit          all_max;
		int unsigned grids;
		int unsigned n;

		grid4 = '{16'hFFFF, 16'h0000, 16'h0003, 16'h0009,
		          16'h0000, 16'hFFFF, 16'h0007, 16'h0001,
		          16'h0002, 16'h0000, 16'hFFFF, 16'h0005,
		          16'h8000, 16'h0001, 16'h0000, 16'hFFFF};

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset size is 4 x 4; edge rows see only one neighbor.
		foreach (grid4[i])
			push_cell(grid4[i]);

		// Zero sizes act as a single cell grid.
		set_size(size_t'(0), size_t'(0));
		push_cell(16'h0000);
		push_cell(16'hFFFF);

		// Rewriting an unchanged size drops the partial grid; spare indexes do not.
		set_size(size_t'(3), size_t'(2));
		push_cell(16'd10);
		push_cell(16'd20);
		write_reg(REG_ROWS, size_t'(3));
		push_cell(16'd4);
		push_cell(16'hFFFF);
		push_cell(16'd6);
		write_reg(REG_SPARE_A, size_t'(7'h7F));
		write_reg(REG_SPARE_B, size_t'(0));
		push_cell(16'd100);
		push_cell(16'd0);
		push_cell(16'd300);

		while (cells_seen < CELL_TARGET) begin
			if (cells_seen < CELL_TARGET / 3) begin
				tx_idle_pct = 18;
				rx_idle_pct = 73;
			end else if (cells_seen < 2 * CELL_TARGET / 3) begin
				tx_idle_pct = 73;
				rx_idle_pct = 18;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			all_max = 1'b0;
			grids   = $urandom_range(1, 4);
			case (settings_used)
				4:  begin rows_v = 7'd127; cols_v = 7'd1;   grids = 1; end
				10: begin rows_v = 7'd1;   cols_v = 7'd64;  grids = 1; end
				16: begin rows_v = 7'd64;  cols_v = 7'd3;   grids = 1; end
				// Every cell at full scale gives the largest possible total.
				22: begin rows_v = 7'd2;   cols_v = 7'd127; grids = 1; all_max = 1'b1; end
				default: begin
					if ($urandom_range(19) == 0) begin
						rows_v = size_t'($urandom_range(64, 127));
						cols_v = size_t'($urandom_range(0, 3));
						if ($urandom_range(1))
							{rows_v, cols_v} = {cols_v, rows_v};
						grids = 1;
					end else begin
						rows_v = size_t'($urandom_range(0, 8));
						cols_v = size_t'($urandom_range(0, 8));
					end
				end
			endcase
			set_size(rows_v, cols_v);

			for (int unsigned g = 0; g < grids; g++) begin
				n = grid_cells;
				if (g == grids - 1 && n > 1 && $urandom_range(7) == 0) begin
					n = $urandom_range(1, n - 1);
					grids_cut++;
				end
				push_grid(n, all_max);
			end
		end

		// One-cell grids behind a long output hold-off: a finished total waits and
		// the block has to stall further cells.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_size(size_t'(1), size_t'(1));
		@(posedge clk);
		hold_off_left = 300;
		@(negedge clk);
		push_grid(40, 1'b0);

		s_axis_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Run covered %0d cells and %0d grid totals over %0d size settings, %0d grids cut short.",
			cells_seen, totals_seen, settings_used, grids_cut);
		$display("Sizes ran from one cell to 64 rows or columns, with zero and oversized registers and a held-off output.");
		if (mismatches == 0)
			$display("grid_max_path_sum test passed");
		else
			$display("grid_max_path_sum test failed");
		$finish;
	end

endmodule
